### design/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    // Fixed widths of the stream fields
    localparam int KEY_FIELD_W   = 64;
    localparam int LEN_W         = 4;
    localparam int VALUE_FIELD_W = 32;
    localparam int IN_TDATA_W    = 104;
    localparam int OUT_TDATA_W   = 104;
    localparam int CAP_W         = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds carried in the slave tuser bit
    localparam logic REQ_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Per-cell strobes from the sequencer
    typedef struct packed {
        logic cmp;
        logic load;
    } t_cell_ctl;

endpackage

### design/lkvc_cell.sv
// One entry of the recency-ordered chain: stored key, length, value and compare.
module lkvc_cell #(
    parameter int KEY_W   = 64,
    parameter int VALUE_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lkvc_pkg::t_cell_ctl      i_ctl,
    input  logic [KEY_W-1:0]         i_req_key,
    input  logic [lkvc_pkg::LEN_W-1:0] i_req_len,
    input  logic                     i_prev_valid,
    input  logic [KEY_W-1:0]         i_prev_key,
    input  logic [lkvc_pkg::LEN_W-1:0] i_prev_len,
    input  logic [VALUE_W-1:0]       i_prev_value,
    input  logic                     i_below,
    output logic                     o_valid,
    output logic [KEY_W-1:0]         o_key,
    output logic [lkvc_pkg::LEN_W-1:0] o_len,
    output logic [VALUE_W-1:0]       o_value,
    output logic                     o_match,
    output logic                     o_below
);
    import lkvc_pkg::*;

    logic               r_valid;
    logic               r_match;
    logic [KEY_W-1:0]   r_key;
    logic [LEN_W-1:0]   r_len;
    logic [VALUE_W-1:0] r_value;
    logic               n_match;

    // Exact compare of key and length against the pending request
    assign n_match = r_valid && (r_key == i_req_key) && (r_len == i_req_len);

    // Hold valid and match flags, take the neighbor's entry on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= n_match;
            end
            if (i_ctl.load) begin
                r_valid <= i_prev_valid;
            end
        end
    end

    // Entry payload moves one place down the chain on a shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key   <= i_prev_key;
            r_len   <= i_prev_len;
            r_value <= i_prev_value;
        end
    end

    // Propagate "a match sits at or after this cell" toward the head
    assign o_below = r_match | i_below;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_len   = r_len;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

### design/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
// Requests arrive on the s_axis channel: tuser[0] selects get (0) or put (1),
// tdata carries key, key length and value. Each request yields exactly one
// response on the m_axis channel: tuser holds the hit and evicted flags,
// tdata the returned value and the evicted key and length.
// The capacity register is written through i_cfg_valid / i_cfg_data and
// is always ready; write it only while no request is in flight.
// Entries sit in a chain of cells ordered by recency, head most recent.
// A request passes through a compare state, which compares all cells in
// parallel, and an update state, which shifts the chain up to the matched
// or replaced place and loads the result into the output register. A new
// request is taken in the update state, while the last one completes.
// While the receiver stalls, the result is held and the block waits in its
// update cycle without accepting more requests. Reset empties the cache,
// sets capacity to 16 and drops the output valid; no clearing pass.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BYTES  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields from bit 0: key[63:0], key_len[67:64], value[99:68]
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: req_type
    input  logic [0:0]                          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: value_out[31:0], evicted_key[95:32], evicted_length[99:96]
    output logic [lkvc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Fields from bit 0: hit, evicted
    output logic [1:0]                          m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    input  logic [lkvc_pkg::CAP_W-1:0]          i_cfg_data,
    output logic                                o_cfg_ready
);
    import lkvc_pkg::*;

    localparam int KW   = 8 * KEY_BYTES;
    localparam int VW   = VALUE_BITS;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

    // Sequencer and configuration
    t_state           r_state, n_state;
    logic [CAP_W-1:0] r_cap;
    logic [OW-1:0]    r_occ;
    logic             w_accept, w_cmp, w_upd_go;

    // Pending request
    logic             r_req_put;
    logic [KW-1:0]    r_req_key;
    logic [LEN_W-1:0] r_req_len;
    logic [VW-1:0]    r_req_val;
    logic [LEN_W-1:0] w_in_len;
    logic [KW-1:0]    w_in_key;

    // Output register
    logic                     r_out_valid;
    logic                     r_hit;
    logic                     r_evicted;
    logic [VALUE_FIELD_W-1:0] r_value_out;
    logic [KEY_FIELD_W-1:0]   r_ev_key;
    logic [LEN_W-1:0]         r_ev_len;

    // Chain wiring
    logic               w_valid [ENTRIES];
    logic [KW-1:0]      w_key   [ENTRIES];
    logic [LEN_W-1:0]   w_len   [ENTRIES];
    logic [VW-1:0]      w_value [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_valid_vec;
    logic [ENTRIES:0]   w_below;
    logic [ENTRIES-1:0] w_therm;
    logic [ENTRIES-1:0] w_evsel;
    t_cell_ctl          w_ctl [ENTRIES];

    logic             w_hit, w_full;
    logic [CMPW-1:0]  w_effcap;
    logic [OW-1:0]    w_bound;
    logic [VW-1:0]    w_match_val, w_head_val;
    logic [KW-1:0]    w_ev_key;
    logic [LEN_W-1:0] w_ev_len;

    // Clamp the length and clear key bytes beyond it
    always_comb begin
        w_in_len = (s_axis_tdata[67:64] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                             : s_axis_tdata[67:64];
        for (int b = 0; b < KEY_BYTES; b++) begin
            w_in_key[8*b +: 8] = (LEN_W'(b) < w_in_len) ? s_axis_tdata[8*b +: 8] : 8'd0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_go) n_state = w_accept ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_cmp         = 1'b0;
        w_upd_go      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_CMP: begin
                w_cmp = 1'b1;
            end
            S_UPD: begin
                w_upd_go      = !r_out_valid || m_axis_tready;
                s_axis_tready = w_upd_go;
            end
            default: ;
        endcase
    end

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Capacity clamp and the full test
    always_comb begin
        if (r_cap == '0) begin
            w_effcap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(ENTRIES)) begin
            w_effcap = CMPW'(ENTRIES);
        end else begin
            w_effcap = CMPW'(r_cap);
        end
    end

    assign w_full  = CMPW'(r_occ) >= w_effcap;
    assign w_hit   = w_below[0];
    assign w_bound = w_full ? (r_occ - OW'(1)) : r_occ;
    assign w_below[ENTRIES] = 1'b0;

    // Select the matched value and the least recent entry
    always_comb begin
        w_match_val = '0;
        w_ev_key    = '0;
        w_ev_len    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match_val = w_match_val | (w_match[i] ? w_value[i] : '0);
            w_ev_key    = w_ev_key | (w_evsel[i] ? w_key[i] : '0);
            w_ev_len    = w_ev_len | (w_evsel[i] ? w_len[i] : '0);
        end
    end

    assign w_head_val = (w_hit && !r_req_put) ? w_match_val : r_req_val;

    // Cell chain: head takes the request, each cell takes its upper neighbor
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam logic [OW-1:0] LANE = OW'(g);

        logic             w_pv;
        logic [KW-1:0]    w_pk;
        logic [LEN_W-1:0] w_pl;
        logic [VW-1:0]    w_pval;

        assign w_therm[g] = LANE <= w_bound;
        assign w_evsel[g] = LANE == (r_occ - OW'(1));
        assign w_ctl[g].cmp  = w_cmp;
        assign w_ctl[g].load = w_upd_go && (w_hit || r_req_put)
                               && (w_hit ? w_below[g] : w_therm[g]);
        assign w_valid_vec[g] = w_valid[g];

        if (g == 0) begin : g_head
            assign w_pv   = 1'b1;
            assign w_pk   = r_req_key;
            assign w_pl   = r_req_len;
            assign w_pval = w_head_val;
        end else begin : g_body
            assign w_pv   = w_valid[g-1];
            assign w_pk   = w_key[g-1];
            assign w_pl   = w_len[g-1];
            assign w_pval = w_value[g-1];
        end

        lkvc_cell #(
            .KEY_W   (KW),
            .VALUE_W (VW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_req_key    (r_req_key),
            .i_req_len    (r_req_len),
            .i_prev_valid (w_pv),
            .i_prev_key   (w_pk),
            .i_prev_len   (w_pl),
            .i_prev_value (w_pval),
            .i_below      (w_below[g+1]),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_len        (w_len[g]),
            .o_value      (w_value[g]),
            .o_match      (w_match[g]),
            .o_below      (w_below[g])
        );
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_upd_go && !w_hit && r_req_put && !w_full) begin
                r_occ <= r_occ + OW'(1);
            end
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the request on acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_put <= (s_axis_tuser[0] == REQ_PUT);
            r_req_key <= w_in_key;
            r_req_len <= w_in_len;
            r_req_val <= VW'(s_axis_tdata[99:68]);
        end
    end

    // Load the response
    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_hit       <= w_hit;
            r_evicted   <= !w_hit && r_req_put && w_full;
            r_value_out <= (w_hit || r_req_put) ? VALUE_FIELD_W'(w_head_val) : '0;
            r_ev_key    <= (!w_hit && r_req_put && w_full) ? KEY_FIELD_W'(w_ev_key) : '0;
            r_ev_len    <= (!w_hit && r_req_put && w_full) ? w_ev_len : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_evicted, r_hit};
    assign m_axis_tdata  = {4'd0, r_ev_len, r_ev_key, r_value_out};

    // At most one entry matches a request
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $onehot0(w_match))
        else $error("more than one entry matched");

    // Valid entries are exactly the occupancy count
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_occ))
        else $error("valid entries disagree with occupancy");

    // An insert into a store with room grows it by one
    a_occ_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_go && r_req_put && !w_hit && !w_full) |=> (r_occ == $past(r_occ) + OW'(1)))
        else $error("occupancy did not grow on insert");

    // Eviction only happens for a put that missed
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_evicted) |-> !r_hit)
        else $error("eviction reported with a hit");

endmodule
